// ===== hw/rtl/tsbr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Tagged sample buffer ring: shared definitions
// Sizes of the buffer ring, field widths, the controller state type and the
// small helper functions used by the controller and the queue.
// ----------------------------------------------------------------------------
package tsbr_pkg;

    // Ring geometry.
    localparam int BUFFER_COUNT = 4;
    localparam int BUFFER_WORDS = 64;
    localparam int RING_SIZE    = BUFFER_COUNT + 1;

    // Derived widths.
    localparam int BUF_W  = $clog2(RING_SIZE);
    localparam int OFF_W  = (BUFFER_WORDS > 1) ? $clog2(BUFFER_WORDS) : 1;
    localparam int CNT_W  = $clog2(BUFFER_WORDS + 1);
    localparam int ADDR_W = $clog2(RING_SIZE * BUFFER_WORDS);
    localparam int QIDX_W = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
    localparam int QCNT_W = $clog2(BUFFER_COUNT + 1);

    // Field widths.
    localparam int CH_W   = 4;
    localparam int SMP_W  = 12;
    localparam int TIME_W = 48;
    localparam int WORD_W = CH_W + SMP_W;
    localparam int IDX_W  = 4;

    // Stream payload widths.
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_FIELD_W = WORD_W + TIME_W + IDX_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    // Request kinds carried in the input tuser bit.
    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMPTY,
        ST_STREAM
    } t_state;

    // Write port of the sample store.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } t_word_wr;

    // Write port of the start time table.
    typedef struct packed {
        logic              en;
        logic [BUF_W-1:0]  idx;
        logic [TIME_W-1:0] stamp;
    } t_time_wr;

    // Commands to the ready queue.
    typedef struct packed {
        logic             push;
        logic             pop;
        logic [BUF_W-1:0] push_idx;
    } t_q_ctrl;

    // Status from the ready queue.
    typedef struct packed {
        logic             nonempty;
        logic [BUF_W-1:0] head_idx;
    } t_q_stat;

    function automatic logic [BUF_W-1:0] ring_next(input logic [BUF_W-1:0] idx);
        logic [BUF_W-1:0] nxt;
        nxt = (idx == BUF_W'(RING_SIZE - 1)) ? '0 : idx + BUF_W'(1);
        return nxt;
    endfunction

    function automatic logic [QIDX_W-1:0] qidx_next(input logic [QIDX_W-1:0] idx);
        logic [QIDX_W-1:0] nxt;
        nxt = (idx == QIDX_W'(BUFFER_COUNT - 1)) ? '0 : idx + QIDX_W'(1);
        return nxt;
    endfunction

    function automatic logic [ADDR_W-1:0] buf_addr(input logic [BUF_W-1:0] bidx,
                                                   input logic [OFF_W-1:0] off);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(bidx) * ADDR_W'(BUFFER_WORDS);
        return base + ADDR_W'(off);
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tsbr_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Tagged sample buffer ring: sample store and start time table
// One synchronous RAM for the words of all ring buffers and a small table of
// buffer start times. Both reads are registered and hold without an enable.
// ----------------------------------------------------------------------------
module tsbr_store (
    input  wire                          i_clk,
    input  wire tsbr_pkg::t_word_wr      i_word_wr,
    input  wire                          i_rd_en,
    input  wire [tsbr_pkg::ADDR_W-1:0]   i_rd_addr,
    output logic [tsbr_pkg::WORD_W-1:0]  o_rd_word,
    input  wire tsbr_pkg::t_time_wr      i_time_wr_a,
    input  wire tsbr_pkg::t_time_wr      i_time_wr_b,
    input  wire                          i_time_re,
    input  wire [tsbr_pkg::BUF_W-1:0]    i_time_idx,
    output logic [tsbr_pkg::TIME_W-1:0]  o_time
);

    localparam int DEPTH = tsbr_pkg::RING_SIZE * tsbr_pkg::BUFFER_WORDS;

    logic [tsbr_pkg::WORD_W-1:0] r_words [DEPTH];
    logic [tsbr_pkg::TIME_W-1:0] r_times [tsbr_pkg::RING_SIZE];

    always_ff @(posedge i_clk) begin
        if (i_word_wr.en) begin
            r_words[i_word_wr.addr] <= i_word_wr.data;
        end
        if (i_rd_en) begin
            o_rd_word <= r_words[i_rd_addr];
        end
    end

    // Both stamp ports can fire together only for one-word buffers, and
    // then they always name different buffers.
    always_ff @(posedge i_clk) begin
        if (i_time_wr_a.en) begin
            r_times[i_time_wr_a.idx] <= i_time_wr_a.stamp;
        end
        if (i_time_wr_b.en) begin
            r_times[i_time_wr_b.idx] <= i_time_wr_b.stamp;
        end
        if (i_time_re) begin
            o_time <= r_times[i_time_idx];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/tsbr_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Tagged sample buffer ring: ready queue
// Circular queue of filled buffer indexes. A push into a full queue drops the
// oldest entry, so the newest filled buffers are always kept.
// ----------------------------------------------------------------------------
module tsbr_queue (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire tsbr_pkg::t_q_ctrl  i_ctrl,
    output tsbr_pkg::t_q_stat       o_stat
);

    localparam int SUM_W = tsbr_pkg::QCNT_W + 1;

    logic [tsbr_pkg::BUF_W-1:0]  r_entry [tsbr_pkg::BUFFER_COUNT];
    logic [tsbr_pkg::QIDX_W-1:0] r_head, n_head;
    logic [tsbr_pkg::QCNT_W-1:0] r_count, n_count;

    logic [SUM_W-1:0]            tail_sum;
    logic [tsbr_pkg::QIDX_W-1:0] tail;
    logic [tsbr_pkg::QIDX_W-1:0] wr_pos;
    logic                        full;

    always_comb begin
        tail_sum = SUM_W'(r_head) + SUM_W'(r_count);
        if (tail_sum >= SUM_W'(tsbr_pkg::BUFFER_COUNT)) begin
            tail = tsbr_pkg::QIDX_W'(tail_sum - SUM_W'(tsbr_pkg::BUFFER_COUNT));
        end else begin
            tail = tsbr_pkg::QIDX_W'(tail_sum);
        end
        full = (r_count == tsbr_pkg::QCNT_W'(tsbr_pkg::BUFFER_COUNT));

        // When full, the new entry takes the slot of the dropped oldest one.
        wr_pos  = full ? r_head : tail;
        n_head  = r_head;
        n_count = r_count;
        if (i_ctrl.push) begin
            if (full) begin
                n_head = tsbr_pkg::qidx_next(r_head);
            end else begin
                n_count = r_count + tsbr_pkg::QCNT_W'(1);
            end
        end else if (i_ctrl.pop) begin
            n_head  = tsbr_pkg::qidx_next(r_head);
            n_count = r_count - tsbr_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_entry[wr_pos] <= i_ctrl.push_idx;
        end
    end

    assign o_stat.nonempty = (r_count != '0);
    assign o_stat.head_idx = r_entry[r_head];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tsbr_pkg::QCNT_W'(tsbr_pkg::BUFFER_COUNT))
        else $error("ready queue count above its depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.pop |-> (r_count != '0) && !i_ctrl.push)
        else $error("ready queue popped while empty or together with a push");

endmodule
`default_nettype wire

// ===== hw/rtl/tagged_sample_buffer_ring.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Tagged sample buffer ring
// Captures tagged converter samples into a ring of buffers, queues filled
// buffers with drop-oldest policy and streams a queued buffer on request.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Moves                          Fields (low bit first)
//  s_axis   in         one store or read request      tdata: channel, sample,
//                                                     now_us; tuser: command
//  m_axis   out        one buffer word or empty mark  tdata: word, start_time,
//                                                     buffer_index, pad;
//                                                     tuser: empty_res;
//                                                     tlast: last
//
// A store request makes a sample RAM write, plus a stamp when a buffer starts.
// A read request pops the ready queue; its words pass through the registered RAM read and then
// the output register, one per cycle while m_axis does not stall, paced by the single read port of the sample RAM.
// s_axis reopens once a read has moved its final word, or its empty mark, to the output register.
// Reset is synchronous and active low; it clears the control state, not the RAM contents.
// An m_axis stall holds the output and pauses RAM reads; s_axis is taken only when idle.
// ----------------------------------------------------------------------------
module tagged_sample_buffer_ring (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // channel [3:0], sample [15:4], now_us [63:16]
    input  wire [tsbr_pkg::IN_TDATA_W-1:0]        i_s_axis_tdata,
    // command [0]
    input  wire                                   i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  wire                                   i_m_axis_tready,
    // word [15:0], start_time [63:16], buffer_index [67:64], zero pad above
    output logic [tsbr_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // empty_res [0]
    output logic                                  o_m_axis_tuser,
    output logic                                  o_m_axis_tlast
);

    // Unpacked request fields.
    logic [tsbr_pkg::CH_W-1:0]   in_channel;
    logic [tsbr_pkg::SMP_W-1:0]  in_sample;
    logic [tsbr_pkg::TIME_W-1:0] in_now;

    assign in_channel = i_s_axis_tdata[tsbr_pkg::CH_W-1:0];
    assign in_sample  = i_s_axis_tdata[tsbr_pkg::CH_W +: tsbr_pkg::SMP_W];
    assign in_now     = i_s_axis_tdata[tsbr_pkg::WORD_W +: tsbr_pkg::TIME_W];

    // Controller state.
    tsbr_pkg::t_state r_state, n_state;

    // Writer side: current buffer, offset inside it, first stamp flag.
    logic [tsbr_pkg::BUF_W-1:0] r_wr_buf, n_wr_buf;
    logic [tsbr_pkg::OFF_W-1:0] r_wr_off, n_wr_off;
    logic                       r_first_pending, n_first_pending;

    // Reader side: buffer being read and number of RAM reads issued.
    logic [tsbr_pkg::BUF_W-1:0] r_rd_buf, n_rd_buf;
    logic [tsbr_pkg::CNT_W-1:0] r_iss_cnt, n_iss_cnt;

    // The RAM output holds a word not yet moved to the output register.
    logic r_p_valid, n_p_valid;
    logic r_p_last, n_p_last;

    // Output register.
    logic                        r_out_valid, n_out_valid;
    logic [tsbr_pkg::WORD_W-1:0] r_out_word, n_out_word;
    logic [tsbr_pkg::TIME_W-1:0] r_out_time, n_out_time;
    logic [tsbr_pkg::IDX_W-1:0]  r_out_idx, n_out_idx;
    logic                        r_out_empty, n_out_empty;
    logic                        r_out_last, n_out_last;

    // Connections to the store and the queue.
    tsbr_pkg::t_word_wr word_wr;
    tsbr_pkg::t_time_wr time_wr_a, time_wr_b;
    tsbr_pkg::t_q_ctrl  q_ctrl;
    tsbr_pkg::t_q_stat  q_stat;
    logic                        rd_en;
    logic [tsbr_pkg::ADDR_W-1:0] rd_addr;
    logic [tsbr_pkg::WORD_W-1:0] rd_word;
    logic                        time_re;
    logic [tsbr_pkg::TIME_W-1:0] rd_time;

    logic in_acc, out_free, move, issue, wr_full;
    logic [tsbr_pkg::BUF_W-1:0] next_buf, step_buf;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign move     = r_p_valid && out_free;
    assign issue    = (r_state == tsbr_pkg::ST_STREAM)
                   && (r_iss_cnt != tsbr_pkg::CNT_W'(tsbr_pkg::BUFFER_WORDS))
                   && (!r_p_valid || move);

    // The next write buffer skips the one the reader last took.
    assign wr_full  = (r_wr_off == tsbr_pkg::OFF_W'(tsbr_pkg::BUFFER_WORDS - 1));
    assign step_buf = tsbr_pkg::ring_next(r_wr_buf);
    assign next_buf = (step_buf == r_rd_buf) ? tsbr_pkg::ring_next(step_buf) : step_buf;

    always_comb begin
        n_state         = r_state;
        n_wr_buf        = r_wr_buf;
        n_wr_off        = r_wr_off;
        n_first_pending = r_first_pending;
        n_rd_buf        = r_rd_buf;
        n_iss_cnt       = r_iss_cnt;
        n_p_valid       = r_p_valid;
        n_p_last        = r_p_last;
        n_out_valid     = r_out_valid && !i_m_axis_tready;
        n_out_word      = r_out_word;
        n_out_time      = r_out_time;
        n_out_idx       = r_out_idx;
        n_out_empty     = r_out_empty;
        n_out_last      = r_out_last;

        word_wr.en      = 1'b0;
        word_wr.addr    = tsbr_pkg::buf_addr(r_wr_buf, r_wr_off);
        word_wr.data    = {in_channel, in_sample};
        time_wr_a.en    = 1'b0;
        time_wr_a.idx   = r_wr_buf;
        time_wr_a.stamp = in_now;
        time_wr_b.en    = 1'b0;
        time_wr_b.idx   = next_buf;
        time_wr_b.stamp = in_now;
        q_ctrl.push     = 1'b0;
        q_ctrl.pop      = 1'b0;
        q_ctrl.push_idx = r_wr_buf;
        time_re         = 1'b0;
        rd_en           = issue;
        rd_addr         = tsbr_pkg::buf_addr(r_rd_buf, r_iss_cnt[tsbr_pkg::OFF_W-1:0]);

        unique case (r_state)
            tsbr_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_s_axis_tuser == tsbr_pkg::CMD_STORE) begin
                        word_wr.en      = 1'b1;
                        time_wr_a.en    = r_first_pending;
                        n_first_pending = 1'b0;
                        if (wr_full) begin
                            q_ctrl.push  = 1'b1;
                            time_wr_b.en = 1'b1;
                            n_wr_buf     = next_buf;
                            n_wr_off     = '0;
                        end else begin
                            n_wr_off = r_wr_off + tsbr_pkg::OFF_W'(1);
                        end
                    end else if (q_stat.nonempty) begin
                        q_ctrl.pop = 1'b1;
                        time_re    = 1'b1;
                        n_rd_buf   = q_stat.head_idx;
                        n_iss_cnt  = '0;
                        n_state    = tsbr_pkg::ST_STREAM;
                    end else begin
                        n_state = tsbr_pkg::ST_EMPTY;
                    end
                end
            end
            tsbr_pkg::ST_EMPTY: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_word  = '0;
                    n_out_time  = '0;
                    n_out_idx   = '0;
                    n_out_empty = 1'b1;
                    n_out_last  = 1'b0;
                    n_state     = tsbr_pkg::ST_IDLE;
                end
            end
            tsbr_pkg::ST_STREAM: begin
                if (move) begin
                    n_out_valid = 1'b1;
                    n_out_word  = rd_word;
                    n_out_time  = rd_time;
                    n_out_idx   = tsbr_pkg::IDX_W'(r_rd_buf);
                    n_out_empty = 1'b0;
                    n_out_last  = r_p_last;
                    n_p_valid   = 1'b0;
                    if (r_p_last) begin
                        n_state = tsbr_pkg::ST_IDLE;
                    end
                end
                if (issue) begin
                    n_p_valid = 1'b1;
                    n_p_last  = (r_iss_cnt == tsbr_pkg::CNT_W'(tsbr_pkg::BUFFER_WORDS - 1));
                    n_iss_cnt = r_iss_cnt + tsbr_pkg::CNT_W'(1);
                end
            end
            default: begin
                n_state = tsbr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= tsbr_pkg::ST_IDLE;
            r_wr_buf        <= '0;
            r_wr_off        <= '0;
            r_first_pending <= 1'b1;
            r_rd_buf        <= '0;
            r_iss_cnt       <= '0;
            r_p_valid       <= 1'b0;
            r_p_last        <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_wr_buf        <= n_wr_buf;
            r_wr_off        <= n_wr_off;
            r_first_pending <= n_first_pending;
            r_rd_buf        <= n_rd_buf;
            r_iss_cnt       <= n_iss_cnt;
            r_p_valid       <= n_p_valid;
            r_p_last        <= n_p_last;
            r_out_valid     <= n_out_valid;
        end
    end

    // Output payload carries no reset.
    always_ff @(posedge i_clk) begin
        r_out_word  <= n_out_word;
        r_out_time  <= n_out_time;
        r_out_idx   <= n_out_idx;
        r_out_empty <= n_out_empty;
        r_out_last  <= n_out_last;
    end

    tsbr_store u_store (
        .i_clk       (i_clk),
        .i_word_wr   (word_wr),
        .i_rd_en     (rd_en),
        .i_rd_addr   (rd_addr),
        .o_rd_word   (rd_word),
        .i_time_wr_a (time_wr_a),
        .i_time_wr_b (time_wr_b),
        .i_time_re   (time_re),
        .i_time_idx  (q_stat.head_idx),
        .o_time      (rd_time)
    );

    tsbr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (q_ctrl),
        .o_stat  (q_stat)
    );

    assign o_s_axis_tready = (r_state == tsbr_pkg::ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{tsbr_pkg::OUT_PAD_W{1'b0}}, r_out_idx, r_out_time, r_out_word};
    assign o_m_axis_tuser  = r_out_empty;
    assign o_m_axis_tlast  = r_out_last;

    a_idle_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !r_p_valid)
        else $error("requests taken while a read word is still pending");

    a_issue_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |=> r_p_valid)
        else $error("issued RAM read did not mark a pending word");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && r_p_last) |=> (r_state == tsbr_pkg::ST_IDLE) && r_out_last)
        else $error("stream did not end after its final word");

endmodule
`default_nettype wire

// ===== dv/tagged_sample_buffer_ring_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tagged sample buffer ring: block-level test
// Sends store and read requests into the block and keeps a shadow copy of the
// buffer ring, the start time table and the ready queue. Every read request
// is expanded into the words that the block must stream back, and each word
// taken from the output is checked field by field against the oldest one
// still waiting. Both stream sides idle at random, and one phase stalls the
// output long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module tagged_sample_buffer_ring_test;

    localparam int LONG_HOLD    = 400;     // cycles of output stall in one test
    localparam int TAIL_CYCLES  = 16;      // settle time after the last word
    localparam int RANDOM_ITEMS = 20;
    localparam int TIMEOUT_NS   = 200_000; // far above the length of a clean run

    // One word of a buffer readout as it appears on the output stream.
    typedef struct packed {
        logic [tsbr_pkg::WORD_W-1:0] word;
        logic [tsbr_pkg::TIME_W-1:0] start_time;
        logic [tsbr_pkg::IDX_W-1:0]  buffer_index;
        logic                        empty_res;
        logic                        last;
    } t_readout;

    logic                             i_clk           = 1'b0;
    logic                             i_rst_n         = 1'b0;
    logic                             i_s_axis_tvalid = 1'b0;
    wire                              o_s_axis_tready;
    // channel [3:0], sample [15:4], now_us [63:16]
    logic [tsbr_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;
    // command [0]
    logic                             i_s_axis_tuser  = 1'b0;
    wire                              o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b0;
    // word [15:0], start_time [63:16], buffer_index [67:64], zero pad above
    wire [tsbr_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata;
    // empty_res [0]
    wire                              o_m_axis_tuser;
    wire                              o_m_axis_tlast;

    // Shadow of the block state. The ring and the stamp table are only read
    // for buffers that went through the ready queue, so they were written.
    logic [tsbr_pkg::WORD_W-1:0] ring_words  [tsbr_pkg::RING_SIZE][tsbr_pkg::BUFFER_WORDS];
    logic [tsbr_pkg::TIME_W-1:0] ring_stamps [tsbr_pkg::RING_SIZE];
    int unsigned       fill_buf      = 0;
    int unsigned       fill_off      = 0;
    int unsigned       drain_buf     = 0;
    bit                stamp_pending = 1'b1;
    int unsigned       ready_list[$];

    // Words the block still owes us, oldest first.
    t_readout          pending_words[$];
    int                mismatch_count = 0;

    // Random idling on both sides, and the long output stall handshake.
    bit                gaps_on     = 1'b1;
    int                hold_ticket = 0;
    int                hold_taken  = 0;
    int                hold_left   = 0;

    tagged_sample_buffer_ring i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // A store request writes one word. The very first sample after reset also
    // stamps the first buffer. A full buffer joins the ready queue, dropping
    // the oldest entry when the queue is full, and writing moves on to the
    // next buffer of the ring, stepping over the one that was read last.
    task automatic capture_sample(input logic [tsbr_pkg::CH_W-1:0]   ch,
                                  input logic [tsbr_pkg::SMP_W-1:0]  smp,
                                  input logic [tsbr_pkg::TIME_W-1:0] now);
        int unsigned nxt;
        if (stamp_pending) begin
            ring_stamps[fill_buf] = now;
            stamp_pending = 1'b0;
        end
        ring_words[fill_buf][fill_off] = {ch, smp};
        fill_off++;
        if (fill_off == tsbr_pkg::BUFFER_WORDS) begin
            if (ready_list.size() == tsbr_pkg::BUFFER_COUNT)
                ready_list.delete(0);
            ready_list.push_back(fill_buf);
            nxt = (fill_buf + 1) % tsbr_pkg::RING_SIZE;
            if (nxt == drain_buf)
                nxt = (nxt + 1) % tsbr_pkg::RING_SIZE;
            // The new buffer takes the time of the sample that closed the old one.
            ring_stamps[nxt] = now;
            fill_buf = nxt;
            fill_off = 0;
        end
    endtask

    // A read request pops the oldest ready buffer and expects all its words,
    // or a single empty mark when nothing is queued.
    task automatic predict_readout();
        t_readout r;
        if (ready_list.size() == 0) begin
            r = '0;
            r.empty_res = 1'b1;
            pending_words.push_back(r);
        end else begin
            drain_buf = ready_list.pop_front();
            for (int k = 0; k < tsbr_pkg::BUFFER_WORDS; k++) begin
                r.word         = ring_words[drain_buf][k];
                r.start_time   = ring_stamps[drain_buf];
                r.buffer_index = tsbr_pkg::IDX_W'(drain_buf);
                r.empty_res    = 1'b0;
                r.last         = (k == tsbr_pkg::BUFFER_WORDS - 1);
                pending_words.push_back(r);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    function automatic logic [tsbr_pkg::TIME_W-1:0] rand_time();
        return tsbr_pkg::TIME_W'({$urandom, $urandom});
    endfunction

    // Offers one request and returns at the clock edge that accepted it.
    // Valid stays high on return so that back-to-back requests have no gap.
    task automatic send_request(input logic                        cmd,
                                input logic [tsbr_pkg::CH_W-1:0]   ch,
                                input logic [tsbr_pkg::SMP_W-1:0]  smp,
                                input logic [tsbr_pkg::TIME_W-1:0] now);
        while (gaps_on && $urandom_range(99, 0) < 6) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {now, smp, ch};
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        if (cmd == tsbr_pkg::CMD_STORE)
            capture_sample(ch, smp, now);
        else
            predict_readout();
    endtask

    // The block ignores channel, sample and time on a read, so they carry noise.
    task automatic send_read();
        send_request(tsbr_pkg::CMD_READ, tsbr_pkg::CH_W'($urandom),
                     tsbr_pkg::SMP_W'($urandom), rand_time());
    endtask

    task automatic store_run(input int count);
        repeat (count)
            send_request(tsbr_pkg::CMD_STORE, tsbr_pkg::CH_W'($urandom),
                         tsbr_pkg::SMP_W'($urandom), rand_time());
    endtask

    // Stores until the buffer being written is complete and queued.
    task automatic close_buffer();
        store_run(tsbr_pkg::BUFFER_WORDS - fill_off);
    endtask

    // Stops offering and waits until every predicted word has been taken.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // Output ready, with random stalls and, when a test asks for
    // it, one long stall counted here so the test can keep sending meanwhile.
    always @(posedge i_clk) begin
        if (hold_ticket != hold_taken) begin
            hold_taken = hold_ticket;
            hold_left  = LONG_HOLD;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= !(gaps_on && $urandom_range(99, 0) < 6);
        end
    end

    task automatic report_mismatch(input string       what,
                                   input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("[%0t] mismatch in %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Every accepted word is held against the oldest word still expected.
    always @(posedge i_clk) begin
        t_readout got;
        t_readout want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.word         = o_m_axis_tdata[tsbr_pkg::WORD_W-1:0];
            got.start_time   = o_m_axis_tdata[tsbr_pkg::WORD_W +: tsbr_pkg::TIME_W];
            got.buffer_index = o_m_axis_tdata[tsbr_pkg::WORD_W + tsbr_pkg::TIME_W +:
                                              tsbr_pkg::IDX_W];
            got.empty_res    = o_m_axis_tuser;
            got.last         = o_m_axis_tlast;
            if (pending_words.size() == 0) begin
                report_mismatch("unexpected word", 64'(got.word), '0);
            end else begin
                want = pending_words.pop_front();
                if (got.word != want.word)
                    report_mismatch("word", 64'(got.word), 64'(want.word));
                if (got.start_time != want.start_time)
                    report_mismatch("start_time", 64'(got.start_time),
                                    64'(want.start_time));
                if (got.buffer_index != want.buffer_index)
                    report_mismatch("buffer_index", 64'(got.buffer_index),
                                    64'(want.buffer_index));
                if (got.empty_res != want.empty_res)
                    report_mismatch("empty_res", 64'(got.empty_res), 64'(want.empty_res));
                if (got.last != want.last)
                    report_mismatch("last", 64'(got.last), 64'(want.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reads right after reset find nothing queued. The ignored fields carry
    // all ones once and all zeros once.
    task automatic test_empty_read();
        send_request(tsbr_pkg::CMD_READ, '1, '1, '1);
        send_request(tsbr_pkg::CMD_READ, '0, '0, '0);
        wait_drained();
    endtask

    // The first buffer opens with the field extremes and checkered patterns;
    // its start time comes from the first sample. It is read back, and a
    // second read then finds the queue empty again.
    task automatic test_field_extremes();
        send_request(tsbr_pkg::CMD_STORE, '0, '0, '1);
        send_request(tsbr_pkg::CMD_STORE, '1, '1, '0);
        send_request(tsbr_pkg::CMD_STORE, 4'hA, 12'h555, 48'hAAAA_AAAA_AAAA);
        send_request(tsbr_pkg::CMD_STORE, 4'h5, 12'hAAA, 48'h5555_5555_5555);
        send_request(tsbr_pkg::CMD_STORE, '0, '1, '1);
        send_request(tsbr_pkg::CMD_STORE, '1, '0, '0);
        close_buffer();
        send_read();
        send_read();
        wait_drained();
    endtask

    // One buffer waits in the queue when the output stalls for a long
    // stretch. The sender keeps offering stores and a read, so the block
    // fills its output and holds off its input until the stall ends.
    task automatic test_output_stall();
        close_buffer();
        hold_ticket++;
        send_read();
        store_run(8);
        send_read();
        wait_drained();
    endtask

    // No random idling on either side; the block still holds off requests while it streams a buffer.
    task automatic test_back_to_back();
        gaps_on = 1'b0;
        close_buffer();
        send_read();
        store_run(6);
        send_read();
        wait_drained();
        gaps_on = 1'b1;
    endtask

    // Mostly stores with reads sprinkled in, into a partly written buffer,
    // so that reads in random places find the queue empty.
    task automatic test_random_mix();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(99, 0) < 10)
                send_read();
            else
                store_run(1);
        end
        wait_drained();
        send_read();
        wait_drained();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_read();
        test_field_extremes();
        test_output_stall();
        test_back_to_back();
        test_random_mix();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_words.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
